### rtl/kau_pkg.sv
`default_nettype none
package kau_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_WIDTH  = 32;
    localparam int COUNT_WIDTH  = 20;

    localparam int ID_WIDTH   = $clog2(MAX_CLUSTERS);
    localparam int ACT_WIDTH  = $clog2(MAX_CLUSTERS + 1);
    localparam int OP_WIDTH   = 2;
    localparam int SUM_WIDTH  = COORD_WIDTH + COUNT_WIDTH;
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int SQ_WIDTH   = 2 * DIFF_WIDTH;
    localparam int DIST_WIDTH = SQ_WIDTH + 1;

    localparam logic [OP_WIDTH-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_ASSIGN = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_FINISH = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [ACT_WIDTH-1:0]   ACT_MAX   = ACT_WIDTH'(MAX_CLUSTERS);

    typedef struct packed {
        logic                load;
        logic                capture;
        logic                issue;
        logic                acc;
        logic                emit_assign;
        logic                emit_finish;
        logic                last;
        logic                clear;
        logic                div_start;
        logic                div_write;
        logic                div_east;
        logic [ID_WIDTH-1:0] idx;
    } kau_cmd_t;

    typedef struct packed {
        logic [ACT_WIDTH-1:0] act;
        logic                 count_nz;
        logic                 div_done;
        logic                 out_free;
    } kau_status_t;

endpackage
`default_nettype wire

### rtl/kau_div.sv
`default_nettype none
module kau_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [kau_pkg::SUM_WIDTH-1:0] dividend,
    input  wire logic [kau_pkg::COUNT_WIDTH-1:0]     divisor,
    output logic                                     busy,
    output logic                                     done,
    output logic signed [kau_pkg::COORD_WIDTH-1:0]   quotient
);
    import kau_pkg::*;

    localparam int STEP_W = $clog2(SUM_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic [SUM_WIDTH-1:0]   q_reg, q_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] div_reg, div_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_WIDTH:0]   rem_t;
    logic                   ge;
    logic [COORD_WIDTH-1:0] q_low;

    assign rem_t = {rem_reg, q_reg[SUM_WIDTH-1]};
    assign ge    = rem_t >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_WIDTH-1];
            q_next    = dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, msb first
            rem_next = ge ? COUNT_WIDTH'(rem_t - {1'b0, div_reg})
                          : rem_t[COUNT_WIDTH-1:0];
            q_next   = {q_reg[SUM_WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(SUM_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    assign q_low    = q_reg[COORD_WIDTH-1:0];
    assign quotient = neg_reg ? (~q_low + 1'b1) : q_low;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

### rtl/kau_datapath.sv
`default_nettype none
module kau_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire kau_pkg::kau_cmd_t                     cmd,
    output kau_pkg::kau_status_t                       status,
    input  wire logic                                  cfg_we,
    input  wire logic [kau_pkg::ACT_WIDTH-1:0]         cfg_wdata,
    input  wire logic [kau_pkg::ID_WIDTH-1:0]          slot,
    input  wire logic signed [kau_pkg::COORD_WIDTH-1:0] coord_north,
    input  wire logic signed [kau_pkg::COORD_WIDTH-1:0] coord_east,
    input  wire logic [kau_pkg::ID_WIDTH-1:0]          prior_cluster,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [kau_pkg::ID_WIDTH-1:0]               cluster_id,
    output logic signed [kau_pkg::COORD_WIDTH-1:0]     centre_north,
    output logic signed [kau_pkg::COORD_WIDTH-1:0]     centre_east,
    output logic [kau_pkg::COUNT_WIDTH-1:0]            member_count,
    output logic                                       last
);
    import kau_pkg::*;

    logic [ACT_WIDTH-1:0]          act_cfg_reg;
    logic [ACT_WIDTH-1:0]          act;
    logic signed [COORD_WIDTH-1:0] cn_reg [MAX_CLUSTERS];
    logic signed [COORD_WIDTH-1:0] ce_reg [MAX_CLUSTERS];
    logic signed [SUM_WIDTH-1:0]   sn_reg [MAX_CLUSTERS];
    logic signed [SUM_WIDTH-1:0]   se_reg [MAX_CLUSTERS];
    logic [COUNT_WIDTH-1:0]        cnt_reg [MAX_CLUSTERS];

    logic signed [COORD_WIDTH-1:0] pn_reg, pe_reg;
    logic [ID_WIDTH-1:0]           prior_reg;
    logic [ID_WIDTH-1:0]           pref;

    logic                          s1_v_reg, s2_v_reg;
    logic [ID_WIDTH-1:0]           s1_idx_reg, s2_idx_reg;
    logic [DIFF_WIDTH-1:0]         dn_reg, de_reg;
    logic [SQ_WIDTH-1:0]           sqn_reg, sqe_reg;
    logic [ID_WIDTH-1:0]           best_reg;
    logic [DIST_WIDTH-1:0]         bd_reg;

    logic signed [DIFF_WIDTH-1:0]  diff_n, diff_e;
    logic [DIST_WIDTH-1:0]         dist_sum;
    logic                          take;

    logic                          out_valid_reg, out_valid_next;
    logic [ID_WIDTH-1:0]           oid_reg;
    logic signed [COORD_WIDTH-1:0] on_reg, oe_reg;
    logic [COUNT_WIDTH-1:0]        oc_reg;
    logic                          olast_reg;
    logic                          out_free;
    logic                          emit;

    logic                          div_busy, div_done;
    logic signed [COORD_WIDTH-1:0] div_q;
    logic signed [SUM_WIDTH-1:0]   div_dividend;
    logic                          sat;

    // zero acts as one, above the table size acts as the table size
    assign act = (act_cfg_reg == '0) ? ACT_WIDTH'(1)
               : (act_cfg_reg > ACT_MAX) ? ACT_MAX : act_cfg_reg;
    assign pref = ({1'b0, prior_reg} < act) ? prior_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_cfg_reg <= ACT_WIDTH'(1);
        else if (cfg_we)
            act_cfg_reg <= cfg_wdata;
    end

    // point under assignment
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pn_reg    <= coord_north;
            pe_reg    <= coord_east;
            prior_reg <= prior_cluster;
        end
    end

    // distance pipeline: difference, square, compare
    assign diff_n   = DIFF_WIDTH'(pn_reg) - DIFF_WIDTH'(cn_reg[cmd.idx]);
    assign diff_e   = DIFF_WIDTH'(pe_reg) - DIFF_WIDTH'(ce_reg[cmd.idx]);
    assign dist_sum = {1'b0, sqn_reg} + {1'b0, sqe_reg};
    assign take     = (s2_idx_reg == '0) || (dist_sum < bd_reg)
                   || ((dist_sum == bd_reg) && (s2_idx_reg == pref));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= cmd.issue;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= cmd.idx;
        dn_reg     <= diff_n[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff_n) : diff_n;
        de_reg     <= diff_e[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff_e) : diff_e;
        s2_idx_reg <= s1_idx_reg;
        sqn_reg    <= dn_reg * dn_reg;
        sqe_reg    <= de_reg * de_reg;
        if (s2_v_reg && take)
        begin
            best_reg <= s2_idx_reg;
            bd_reg   <= dist_sum;
        end
    end

    kau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg[cmd.idx]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_dividend = cmd.div_east ? se_reg[cmd.idx] : sn_reg[cmd.idx];
    assign sat          = cnt_reg[best_reg] == COUNT_MAX;

    // centroid table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                cn_reg[i] <= '0;
                ce_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            if ({1'b0, slot} < ACT_MAX)
            begin
                cn_reg[slot] <= coord_north;
                ce_reg[slot] <= coord_east;
            end
        end
        else if (cmd.div_write)
        begin
            if (cmd.div_east)
                ce_reg[cmd.idx] <= div_q;
            else
                cn_reg[cmd.idx] <= div_q;
        end
    end

    // running sums and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                sn_reg[i]  <= '0;
                se_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                sn_reg[i]  <= '0;
                se_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.acc && !sat)
        begin
            cnt_reg[best_reg] <= cnt_reg[best_reg] + 1'b1;
            sn_reg[best_reg]  <= sn_reg[best_reg] + SUM_WIDTH'(pn_reg);
            se_reg[best_reg]  <= se_reg[best_reg] + SUM_WIDTH'(pe_reg);
        end
    end

    // output register
    assign out_free       = !out_valid_reg || !out_stall;
    assign emit           = cmd.emit_assign || cmd.emit_finish;
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_assign)
        begin
            oid_reg   <= best_reg;
            on_reg    <= '0;
            oe_reg    <= '0;
            oc_reg    <= cnt_reg[best_reg];
            olast_reg <= 1'b1;
        end
        else if (cmd.emit_finish)
        begin
            oid_reg   <= cmd.idx;
            on_reg    <= cn_reg[cmd.idx];
            oe_reg    <= ce_reg[cmd.idx];
            oc_reg    <= cnt_reg[cmd.idx];
            olast_reg <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cluster_id   = oid_reg;
    assign centre_north = on_reg;
    assign centre_east  = oe_reg;
    assign member_count = oc_reg;
    assign last         = olast_reg;

    assign status.act      = act;
    assign status.count_nz = cnt_reg[cmd.idx] != '0;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_assign || cmd.emit_finish) |-> out_free)
        else $error("result written over a pending one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc && !cmd.clear) |=> (cnt_reg[$past(best_reg)] != '0))
        else $error("member count wrapped");

endmodule
`default_nettype wire

### rtl/kau_ctrl.sv
`default_nettype none
module kau_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [kau_pkg::OP_WIDTH-1:0]  op,
    input  wire kau_pkg::kau_status_t          status,
    output kau_pkg::kau_cmd_t                  cmd
);
    import kau_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_DRAIN  = 10'b0000000100,
        S_ACC    = 10'b0000001000,
        S_EMIT   = 10'b0000010000,
        S_FSTART = 10'b0000100000,
        S_DIVN   = 10'b0001000000,
        S_ESTART = 10'b0010000000,
        S_DIVE   = 10'b0100000000,
        S_FEMIT  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ID_WIDTH-1:0] idx_reg, idx_next;
    logic                last_idx;

    assign last_idx = (ACT_WIDTH'({1'b0, idx_reg}) + 1'b1) == status.act;
    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_LOAD)
                        cmd.load = 1'b1;
                    else if (op == OP_ASSIGN)
                    begin
                        cmd.capture = 1'b1;
                        idx_next    = '0;
                        state_next  = S_SCAN;
                    end
                    else if (op == OP_FINISH)
                    begin
                        idx_next   = '0;
                        state_next = S_FSTART;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_DRAIN:
            begin
                // wait here for the square and compare stages to finish
                if (idx_reg == ID_WIDTH'(1))
                    state_next = S_ACC;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_assign = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FSTART:
            begin
                if (status.count_nz)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVN;
                end
                else
                    state_next = S_FEMIT;
            end
            S_DIVN:
            begin
                if (status.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_ESTART;
                end
            end
            S_ESTART:
            begin
                cmd.div_east  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIVE;
            end
            S_DIVE:
            begin
                cmd.div_east = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_FEMIT;
                end
            end
            S_FEMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_finish = 1'b1;
                    cmd.last        = last_idx;
                    if (last_idx)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FSTART;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (ACT_WIDTH'({1'b0, idx_reg}) < status.act))
        else $error("scan index beyond active clusters");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEMIT && status.out_free && last_idx) |=> (state_reg == S_IDLE))
        else $error("finish pass did not return to idle");

endmodule
`default_nettype wire

### rtl/kmeans_assign_update_unit.sv
// k-means assign/update unit for 2-D points in signed Q9.22
//
// input channel (in_valid / in_stall): op, slot, coord_north, coord_east,
// prior_cluster. an item is taken on an edge with in_valid high and
// in_stall low. output channel (out_valid / out_stall) carries cluster_id,
// centre_north, centre_east, member_count and last, held while stalled.
// active_clusters is written through cfg_we / cfg_wdata; only while idle, which the user must ensure.
//
// load: slot written on accept, no result. assign: the one-centroid-per-cycle
// distance scan feeds the difference, square and compare stages; then the
// best cluster is updated and its result written. finish: per active cluster
// the shared one-bit-per-cycle divider forms the north then east mean, then
// its result follows, last on the final one. items are taken one at a time.
// a stalled receiver holds the pending result; the unit waits to write the
// next one until the output register frees.
// reset clears centroids, sums and counts and sets active_clusters to one.
`default_nettype none
module kmeans_assign_update_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [kau_pkg::ACT_WIDTH-1:0]          cfg_wdata,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [kau_pkg::OP_WIDTH-1:0]           op,
    input  wire logic [kau_pkg::ID_WIDTH-1:0]           slot,
    input  wire logic signed [kau_pkg::COORD_WIDTH-1:0] coord_north,
    input  wire logic signed [kau_pkg::COORD_WIDTH-1:0] coord_east,
    input  wire logic [kau_pkg::ID_WIDTH-1:0]           prior_cluster,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [kau_pkg::ID_WIDTH-1:0]                cluster_id,
    output logic signed [kau_pkg::COORD_WIDTH-1:0]      centre_north,
    output logic signed [kau_pkg::COORD_WIDTH-1:0]      centre_east,
    output logic [kau_pkg::COUNT_WIDTH-1:0]             member_count,
    output logic                                        last
);
    import kau_pkg::*;

    kau_cmd_t    cmd;
    kau_status_t status;

    kau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    kau_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .slot          (slot),
        .coord_north   (coord_north),
        .coord_east    (coord_east),
        .prior_cluster (prior_cluster),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cluster_id    (cluster_id),
        .centre_north  (centre_north),
        .centre_east   (centre_east),
        .member_count  (member_count),
        .last          (last)
    );

endmodule
`default_nettype wire
